// ===== hw/rtl/bfr_pkg.sv =====
// ============================================================================
// bfr_pkg: shared types and constants of the bitstream field reader
// Buffer geometry, request and status codes, and the structs that pass
// between the top level and the command execution unit.
// ============================================================================
package bfr_pkg;

	localparam int BUFFER_BYTES   = 16;
	localparam int MAX_FIELD_BITS = 64;

	localparam int BUF_BITS = BUFFER_BYTES * 8;
	localparam int SLOT_W   = $clog2(BUFFER_BYTES);
	localparam int HELD_W   = $clog2(BUFFER_BYTES + 1);
	localparam int AVAIL_W  = HELD_W + 3;
	localparam int IDX_W    = $clog2(BUF_BITS);

	localparam logic [2:0] REQ_PUSH    = 3'd0;
	localparam logic [2:0] REQ_RD_U    = 3'd1;
	localparam logic [2:0] REQ_RD_S    = 3'd2;
	localparam logic [2:0] REQ_SKIP    = 3'd3;
	localparam logic [2:0] REQ_UNARY   = 3'd4;
	localparam logic [2:0] REQ_LIMITED = 3'd5;
	localparam logic [2:0] REQ_ALIGN   = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNDERRUN = 2'd1;
	localparam logic [1:0] ST_LIMIT    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0] req;
		logic [7:0] data;
		logic [6:0] count;
		logic       stop;
		logic [6:0] limit;
	} cmd_t;

	// buffered bits, first unconsumed bit at bit 0
	typedef struct packed {
		logic                order;
		logic [BUF_BITS-1:0] bits;
		logic [AVAIL_W-1:0]  avail;
		logic [HELD_W-1:0]   held;
		logic [AVAIL_W-1:0]  align_n;
	} view_t;

	typedef struct packed {
		logic [63:0]        value;
		logic [1:0]         status;
		logic               push;
		logic               consume;
		logic [AVAIL_W-1:0] cons_n;
	} res_t;

endpackage

// ===== hw/rtl/bfr_exec.sv =====
// ============================================================================
// bfr_exec: command execution unit
// Combinational decode of one command against the buffered bit window:
// field gather, sign extension, unary search, underrun, limit and full checks.
// ============================================================================
module bfr_exec import bfr_pkg::*; (
	input  cmd_t  cmd,
	input  view_t view,
	output res_t  res
);

	logic [BUF_BITS-1:0] avm;
	logic [BUF_BITS-1:0] match;
	logic                found;
	logic [IDX_W-1:0]    f_idx;
	logic [6:0]          count_sat;
	logic [6:0]          limit_sat;
	logic [6:0]          cnt_m1;
	logic [63:0]         low64;
	logic [63:0]         rev64;
	logic [63:0]         mask64;
	logic [63:0]         gathered;
	logic [63:0]         field;
	logic [AVAIL_W:0]    avail_x;
	logic [AVAIL_W:0]    cnt_x;
	logic [AVAIL_W:0]    cnt_sat_x;
	logic [AVAIL_W:0]    lim_x;
	logic [AVAIL_W:0]    f_x;

	always_comb begin
		for (int k = 0; k < BUF_BITS; k++) begin
			avm[k] = (AVAIL_W'(k) < view.avail);
		end
	end

	assign match = (cmd.stop ? view.bits : ~view.bits) & avm;

	// lowest position that holds the stop bit
	always_comb begin
		found = 1'b0;
		f_idx = '0;
		for (int k = BUF_BITS - 1; k >= 0; k--) begin
			if (match[k]) begin
				found = 1'b1;
				f_idx = IDX_W'(k);
			end
		end
	end

	always_comb begin
		count_sat = (cmd.count > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS) : cmd.count;
		limit_sat = (cmd.limit > 7'(MAX_FIELD_BITS)) ? 7'(MAX_FIELD_BITS) : cmd.limit;
		cnt_m1    = count_sat - 7'd1;
		low64     = view.bits[63:0];
		for (int k = 0; k < 64; k++) begin
			rev64[k] = low64[63-k];
		end
		mask64 = (count_sat >= 7'd64) ? '1 : ((64'd1 << count_sat) - 64'd1);
		if (view.order) begin
			gathered = low64 & mask64;
		end else if (count_sat == 7'd0) begin
			gathered = '0;
		end else begin
			gathered = rev64 >> (7'd64 - count_sat);
		end
		field = gathered;
		if (cmd.req == REQ_RD_S && count_sat != 7'd0 && count_sat < 7'd64 &&
		    gathered[cnt_m1[5:0]]) begin
			field = gathered | (~64'd0 << count_sat);
		end
	end

	assign avail_x   = {1'b0, view.avail};
	assign cnt_x     = (AVAIL_W+1)'(cmd.count);
	assign cnt_sat_x = (AVAIL_W+1)'(count_sat);
	assign lim_x     = (AVAIL_W+1)'(limit_sat);
	assign f_x       = (AVAIL_W+1)'(f_idx);

	always_comb begin
		res.value   = '0;
		res.status  = ST_OK;
		res.push    = 1'b0;
		res.consume = 1'b0;
		res.cons_n  = '0;
		case (cmd.req)
			REQ_PUSH: begin
				if (view.held >= HELD_W'(BUFFER_BYTES)) begin
					res.status = ST_FULL;
				end else begin
					res.push = 1'b1;
				end
			end
			REQ_RD_U, REQ_RD_S: begin
				if (cnt_sat_x > avail_x) begin
					res.status = ST_UNDERRUN;
				end else begin
					res.value   = field;
					res.consume = 1'b1;
					res.cons_n  = AVAIL_W'(count_sat);
				end
			end
			REQ_SKIP: begin
				if (cnt_x > avail_x) begin
					res.status = ST_UNDERRUN;
				end else begin
					res.consume = 1'b1;
					res.cons_n  = AVAIL_W'(cmd.count);
				end
			end
			REQ_UNARY: begin
				if (!found) begin
					res.status = ST_UNDERRUN;
				end else begin
					res.value   = 64'(f_idx);
					res.consume = 1'b1;
					res.cons_n  = AVAIL_W'(f_idx) + AVAIL_W'(1);
				end
			end
			REQ_LIMITED: begin
				if (found && f_x < lim_x) begin
					res.value   = 64'(f_idx);
					res.consume = 1'b1;
					res.cons_n  = AVAIL_W'(f_idx) + AVAIL_W'(1);
				end else if (lim_x <= avail_x) begin
					res.status  = ST_LIMIT;
					res.consume = 1'b1;
					res.cons_n  = AVAIL_W'(limit_sat);
				end else begin
					res.status = ST_UNDERRUN;
				end
			end
			REQ_ALIGN: begin
				res.consume = 1'b1;
				res.cons_n  = view.align_n;
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

endmodule

// ===== hw/rtl/bitstream_field_reader.sv =====
// ============================================================================
// bitstream_field_reader: byte buffer read back as bit fields
// Pushes bytes into a small window and serves field, skip, unary and align
// commands over it, one command per clock while the output is not stalled.
// ============================================================================
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: req_type,
//   data_byte, bit_count, term_bit, max_bits. Output channel
//   (out_valid/out_ready) returns exactly one result item per command:
//   value and status. Configuration channel (cfg_valid/cfg_ready) writes
//   bit_order; it is taken only while no command is in flight or waiting
//   at the output, and a write also drops the rest of a partly read byte.
//   Path: an accepted item is captured in the input register and decoded
//   from it; its result is written to the result register once that
//   register is free, and is offered on the output from there.
//   Throughput: one item per cycle while the result register is free.
//   The window shift, barrel gather and stop-bit priority encode all finish
//   between input and result registers; buffer state updates at the same edge.
//   Reset: buffer empty, byte aligned, bit_order 0, both channels empty.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more item, then in_ready drops until the
//   result is taken.
//
module bitstream_field_reader import bfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  bit_count,
	input  logic        term_bit,
	input  logic [6:0]  max_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        bit_order
);

	// input stage
	logic valid_s1;
	cmd_t cmd_s1;

	// result register
	logic        out_valid_q;
	logic [63:0] value_q;
	logic [1:0]  status_q;

	// buffer state: win_q[0] always holds the byte at the read position
	logic [7:0]        win_q [BUFFER_BYTES];
	logic [HELD_W-1:0] held_q;
	logic [2:0]        bit_pos_q;
	logic              bit_order_q;

	logic res_free;
	logic fire;
	logic in_fire;
	logic cfg_fire;

	logic [BUF_BITS-1:0] raw_bits;
	view_t               view;
	res_t                res;

	logic               cons_en;
	logic [AVAIL_W-1:0] cons_n;
	logic [AVAIL_W:0]   cons_idx;
	logic [HELD_W-1:0]  drop;
	logic [7:0]         win_sh [BUFFER_BYTES];

	// handshake
	assign res_free  = !out_valid_q || out_ready;
	assign fire      = valid_s1 && res_free;
	assign in_ready  = !valid_s1 || res_free;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = !valid_s1 && !out_valid_q;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1.req   <= req_type;
			cmd_s1.data  <= data_byte;
			cmd_s1.count <= bit_count;
			cmd_s1.stop  <= term_bit;
			cmd_s1.limit <= max_bits;
		end
	end

	// bit stream view: reorder each byte so the next bit to read sits lowest
	always_comb begin
		for (int j = 0; j < BUFFER_BYTES; j++) begin
			for (int i = 0; i < 8; i++) begin
				raw_bits[j*8+i] = bit_order_q ? win_q[j][i] : win_q[j][7-i];
			end
		end
	end

	always_comb begin
		view.order   = bit_order_q;
		view.bits    = raw_bits >> bit_pos_q;
		view.avail   = {held_q, 3'b000} - AVAIL_W'(bit_pos_q);
		view.held    = held_q;
		view.align_n = (bit_pos_q == 3'd0) ? '0 : AVAIL_W'(4'd8 - {1'b0, bit_pos_q});
	end

	bfr_exec u_exec (
		.cmd  (cmd_s1),
		.view (view),
		.res  (res)
	);

	// consume: a config write aligns, as a byte align command does
	assign cons_en  = cfg_fire || (fire && res.consume);
	assign cons_n   = cfg_fire ? view.align_n : res.cons_n;
	assign cons_idx = (AVAIL_W+1)'(bit_pos_q) + (AVAIL_W+1)'(cons_n);
	assign drop     = cons_idx[HELD_W+2:3];

	// advance the window by the dropped bytes
	always_comb begin
		logic [HELD_W:0] src;
		for (int j = 0; j < BUFFER_BYTES; j++) begin
			src = (HELD_W+1)'(j) + (HELD_W+1)'(drop);
			if (src < (HELD_W+1)'(BUFFER_BYTES)) begin
				win_sh[j] = win_q[src[SLOT_W-1:0]];
			end else begin
				win_sh[j] = win_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cons_en) begin
			win_q <= win_sh;
		end else if (fire && res.push) begin
			win_q[held_q[SLOT_W-1:0]] <= cmd_s1.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			bit_pos_q   <= '0;
			bit_order_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				bit_order_q <= bit_order;
			end
			if (cons_en) begin
				held_q    <= held_q - drop;
				bit_pos_q <= cons_idx[2:0];
			end else if (fire && res.push) begin
				held_q <= held_q + HELD_W'(1);
			end
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			value_q  <= res.value;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// checks
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(BUFFER_BYTES))
		else $error("held byte count above buffer size");

	a_pos_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q != 3'd0 |-> held_q != '0)
		else $error("partial bit position with empty buffer");

	a_underrun_stable: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.status == ST_UNDERRUN |=> $stable(held_q) && $stable(bit_pos_q))
		else $error("underrun changed buffer state");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.status == ST_FULL |-> held_q == HELD_W'(BUFFER_BYTES))
		else $error("full status with room in buffer");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q && status_q == $past(res.status))
		else $error("result register missed an item");

endmodule
